@@ rtl/eolsi_pkg.sv @@
// ----------------------------------------------------------------------------
// eolsi_pkg
// Shared types and constants for the even-odd lattice site indexer.
// ----------------------------------------------------------------------------
package eolsi_pkg;

  // Largest lattice extent in any direction
  localparam int MAX_EXTENT = 64;
  localparam int HALF_MAX   = MAX_EXTENT / 2;
  localparam int RESET_HALF = 2;

  // Field widths fixed by the interface
  localparam int CW        = 6;   // coordinate
  localparam int CFG_W     = 6;   // config write data
  localparam int CFG_IDX_W = 1;   // config register index
  localparam int IDX_W     = 24;  // index result

  // Derived internal widths
  localparam int LOG    = $clog2(MAX_EXTENT);
  localparam int HALF_W = $clog2(((HALF_MAX > RESET_HALF) ? HALF_MAX : RESET_HALF) + 1);
  localparam int EXT_W  = LOG + 1;        // LT, LS
  localparam int S2_W   = 2 * LOG + 1;    // LS^2, x + LS*t
  localparam int S3_W   = 3 * LOG + 1;    // LS^3, y + LS*(...)
  localparam int LEX_W  = 4 * LOG + 1;    // lexicographic position, volume
  localparam int CMP_W  = (CW > EXT_W) ? CW : EXT_W;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_HALF  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_HALF = CFG_IDX_W'(1);

  // Direction slots in the wrap flag vectors
  localparam int DIR_Z = 0;
  localparam int DIR_Y = 1;
  localparam int DIR_X = 2;
  localparam int DIR_T = 3;

  typedef struct packed {
    logic [CW-1:0] t_coord;
    logic [CW-1:0] x_coord;
    logic [CW-1:0] y_coord;
    logic [CW-1:0] z_coord;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] site_index;
    logic [IDX_W-1:0] up_t;
    logic [IDX_W-1:0] down_t;
    logic [IDX_W-1:0] up_x;
    logic [IDX_W-1:0] down_x;
    logic [IDX_W-1:0] up_y;
    logic [IDX_W-1:0] down_y;
    logic [IDX_W-1:0] up_z;
    logic [IDX_W-1:0] down_z;
    logic             bad_coordinate;
  } out_rsp_t;

  // Per-site status carried down the pipe
  typedef struct packed {
    logic       bad;
    logic       odd;
    logic [3:0] top;    // coordinate is at extent - 1
    logic [3:0] zero;   // coordinate is 0
  } site_flags_t;

  // Hand-off from the position stages to the neighbor stages
  typedef struct packed {
    site_flags_t        flags;
    logic [EXT_W-1:0]   ls;
    logic [S2_W-1:0]    ls2;
    logic [S3_W-1:0]    ls3;
    logic [LEX_W-1:0]   vol;
    logic [LEX_W-1:0]   lex;
  } base_t;

endpackage

@@ rtl/even_odd_lattice_site_indexer.sv @@
// A request passes the six stage registers, one site each, to out_valid.
// Throughput: one request per cycle unless a full pipe meets out_ready low.
// The pipe stalls per stage from out_ready back to in_ready, filling bubbles.
// Reset (rst_n low, synchronous) empties the pipe and sets both half extents
// to 2 (a 4x4x4x4 lattice).
// ----------------------------------------------------------------------------
// even_odd_lattice_site_indexer
// Even-odd lexicographic index of a 4D lattice site and of its eight wrapped
// nearest neighbors.
// ----------------------------------------------------------------------------
module even_odd_lattice_site_indexer (
  input  logic                            clk,
  input  logic                            rst_n,
  // site requests
  input  eolsi_pkg::in_req_t              in_req,
  input  logic                            in_valid,
  output logic                            in_ready,
  // index results
  output eolsi_pkg::out_rsp_t             out_rsp,
  output logic                            out_valid,
  input  logic                            out_ready,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [eolsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eolsi_pkg::CFG_W-1:0]     cfg_data
);
  import eolsi_pkg::*;

  // Stage map:
  //   1  range check, parity, wrap flags, LS^2, x + LS*t
  //   2  LS^3, y + LS*(x + LS*t)
  //   3  volume LT*LS^3, lex = z + LS*(...)
  //   4  wrap deltas (L-1)*stride, taken from the strides as L*stride - stride
  //   5  eight neighbor positions: lex +/- stride, or the opposite wrap
  //   6  halve, add volume/2 on the odd sublattice, zero on a bad site
  // Lattice extents are even, so every neighbor has the opposite parity.

  logic [HALF_W-1:0] t_half;
  logic [HALF_W-1:0] s_half;
  base_t             base;
  logic              base_valid;
  logic              base_ready;

  // Half extents; user must write only with the pipe empty; not enforced
  eolsi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .t_half    (t_half),
    .s_half    (s_half)
  );

  // Stages 1-3: lexicographic position and lattice sizes
  eolsi_base u_base (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .t_half     (t_half),
    .s_half     (s_half),
    .base       (base),
    .base_valid (base_valid),
    .base_ready (base_ready)
  );

  // Stages 4-6: neighbors and even-odd indices; stage 6 is the output register
  eolsi_nbr u_nbr (
    .clk        (clk),
    .rst_n      (rst_n),
    .base       (base),
    .base_valid (base_valid),
    .base_ready (base_ready),
    .out_rsp    (out_rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

@@ rtl/eolsi_cfg.sv @@
// ----------------------------------------------------------------------------
// eolsi_cfg
// Half-extent registers with clamping on write.
// ----------------------------------------------------------------------------
module eolsi_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [eolsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eolsi_pkg::CFG_W-1:0]     cfg_data,
  output logic [eolsi_pkg::HALF_W-1:0]    t_half,
  output logic [eolsi_pkg::HALF_W-1:0]    s_half
);
  import eolsi_pkg::*;

  logic [HALF_W-1:0] t_half_r, t_half_nxt;
  logic [HALF_W-1:0] s_half_r, s_half_nxt;
  logic [HALF_W-1:0] clamped;

  // zero stores as one, too large stores as the maximum
  always_comb begin
    if (cfg_data == '0) begin
      clamped = HALF_W'(1);
    end else if (int'(cfg_data) > HALF_MAX) begin
      clamped = HALF_W'(HALF_MAX);
    end else begin
      clamped = HALF_W'(cfg_data);
    end
  end

  always_comb begin
    t_half_nxt = t_half_r;
    s_half_nxt = s_half_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_HALF:  t_half_nxt = clamped;
        CFG_SPACE_HALF: s_half_nxt = clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_half_r <= HALF_W'(RESET_HALF);
      s_half_r <= HALF_W'(RESET_HALF);
    end else begin
      t_half_r <= t_half_nxt;
      s_half_r <= s_half_nxt;
    end
  end

  assign t_half = t_half_r;
  assign s_half = s_half_r;

endmodule

@@ rtl/eolsi_base.sv @@
// ----------------------------------------------------------------------------
// eolsi_base
// Three stages: range check and flags, Horner chain for the lexicographic
// position, powers of LS and the lattice volume.
// ----------------------------------------------------------------------------
module eolsi_base (
  input  logic                         clk,
  input  logic                         rst_n,
  input  eolsi_pkg::in_req_t           in_req,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [eolsi_pkg::HALF_W-1:0] t_half,
  input  logic [eolsi_pkg::HALF_W-1:0] s_half,
  output eolsi_pkg::base_t             base,
  output logic                         base_valid,
  input  logic                         base_ready
);
  import eolsi_pkg::*;

  typedef struct packed {
    site_flags_t      flags;
    logic [EXT_W-1:0] lt;
    logic [EXT_W-1:0] ls;
    logic [S2_W-1:0]  ls2;
    logic [S2_W-1:0]  hor1;
    logic [CW-1:0]    y;
    logic [CW-1:0]    z;
  } st1_t;

  typedef struct packed {
    site_flags_t      flags;
    logic [EXT_W-1:0] lt;
    logic [EXT_W-1:0] ls;
    logic [S2_W-1:0]  ls2;
    logic [S3_W-1:0]  ls3;
    logic [S3_W-1:0]  hor2;
    logic [CW-1:0]    z;
  } st2_t;

  st1_t  st1_r, st1_nxt;
  st2_t  st2_r, st2_nxt;
  base_t st3_r, st3_nxt;
  logic  v1_r, v2_r, v3_r;
  logic  rdy1, rdy2, rdy3;

  logic [EXT_W-1:0]      lt, ls;
  logic [EXT_W+CW-1:0]   prod_lt;
  logic [2*EXT_W-1:0]    prod_ls2;
  logic [EXT_W+S2_W-1:0] prod_ls3;
  logic [EXT_W+S2_W-1:0] prod_h2;
  logic [EXT_W+S3_W-1:0] prod_vol;
  logic [EXT_W+S3_W-1:0] prod_lex;

  // bubble-collapsing handshake
  assign rdy3     = !v3_r || base_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1
  always_comb begin
    lt       = EXT_W'({t_half, 1'b0});
    ls       = EXT_W'({s_half, 1'b0});
    prod_lt  = ls * in_req.t_coord;
    prod_ls2 = ls * ls;

    st1_nxt.flags.bad = (CMP_W'(in_req.t_coord) >= CMP_W'(lt)) ||
                        (CMP_W'(in_req.x_coord) >= CMP_W'(ls)) ||
                        (CMP_W'(in_req.y_coord) >= CMP_W'(ls)) ||
                        (CMP_W'(in_req.z_coord) >= CMP_W'(ls));
    st1_nxt.flags.odd = in_req.t_coord[0] ^ in_req.x_coord[0] ^
                        in_req.y_coord[0] ^ in_req.z_coord[0];
    st1_nxt.flags.top[DIR_T]  = (CMP_W'(in_req.t_coord) + CMP_W'(1)) == CMP_W'(lt);
    st1_nxt.flags.top[DIR_X]  = (CMP_W'(in_req.x_coord) + CMP_W'(1)) == CMP_W'(ls);
    st1_nxt.flags.top[DIR_Y]  = (CMP_W'(in_req.y_coord) + CMP_W'(1)) == CMP_W'(ls);
    st1_nxt.flags.top[DIR_Z]  = (CMP_W'(in_req.z_coord) + CMP_W'(1)) == CMP_W'(ls);
    st1_nxt.flags.zero[DIR_T] = in_req.t_coord == '0;
    st1_nxt.flags.zero[DIR_X] = in_req.x_coord == '0;
    st1_nxt.flags.zero[DIR_Y] = in_req.y_coord == '0;
    st1_nxt.flags.zero[DIR_Z] = in_req.z_coord == '0;

    st1_nxt.lt   = lt;
    st1_nxt.ls   = ls;
    st1_nxt.ls2  = S2_W'(prod_ls2);
    st1_nxt.hor1 = S2_W'(prod_lt) + S2_W'(in_req.x_coord);
    st1_nxt.y    = in_req.y_coord;
    st1_nxt.z    = in_req.z_coord;
  end

  // stage 2
  always_comb begin
    prod_ls3 = st1_r.ls2 * st1_r.ls;
    prod_h2  = st1_r.hor1 * st1_r.ls;

    st2_nxt.flags = st1_r.flags;
    st2_nxt.lt    = st1_r.lt;
    st2_nxt.ls    = st1_r.ls;
    st2_nxt.ls2   = st1_r.ls2;
    st2_nxt.ls3   = S3_W'(prod_ls3);
    st2_nxt.hor2  = S3_W'(prod_h2) + S3_W'(st1_r.y);
    st2_nxt.z     = st1_r.z;
  end

  // stage 3
  always_comb begin
    prod_vol = st2_r.ls3 * st2_r.lt;
    prod_lex = st2_r.hor2 * st2_r.ls;

    st3_nxt.flags = st2_r.flags;
    st3_nxt.ls    = st2_r.ls;
    st3_nxt.ls2   = st2_r.ls2;
    st3_nxt.ls3   = st2_r.ls3;
    st3_nxt.vol   = LEX_W'(prod_vol);
    st3_nxt.lex   = LEX_W'(prod_lex) + LEX_W'(st2_r.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) st1_r <= st1_nxt;
    if (rdy2 && v1_r)     st2_r <= st2_nxt;
    if (rdy3 && v2_r)     st3_r <= st3_nxt;
  end

  assign base       = st3_r;
  assign base_valid = v3_r;

endmodule

@@ rtl/eolsi_nbr.sv @@
// ----------------------------------------------------------------------------
// eolsi_nbr
// Three stages: wrap deltas, neighbor positions, even-odd index and output
// register.
// ----------------------------------------------------------------------------
module eolsi_nbr (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eolsi_pkg::base_t     base,
  input  logic                 base_valid,
  output logic                 base_ready,
  output eolsi_pkg::out_rsp_t  out_rsp,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import eolsi_pkg::*;

  typedef struct packed {
    site_flags_t      flags;
    logic [EXT_W-1:0] ls;
    logic [S2_W-1:0]  ls2;
    logic [S3_W-1:0]  ls3;
    logic [LEX_W-1:0] lex;
    logic [LEX_W-2:0] half_vol;
    logic [EXT_W-1:0] dz;
    logic [S2_W-1:0]  dy;
    logic [S3_W-1:0]  dx;
    logic [LEX_W-1:0] dt;
  } st4_t;

  typedef struct packed {
    site_flags_t      flags;
    logic [LEX_W-1:0] lex;
    logic [LEX_W-2:0] half_vol;
    logic [LEX_W-1:0] up_t, dn_t, up_x, dn_x, up_y, dn_y, up_z, dn_z;
  } st5_t;

  st4_t     st4_r, st4_nxt;
  st5_t     st5_r, st5_nxt;
  out_rsp_t st6_r, st6_nxt;
  logic     v4_r, v5_r, v6_r;
  logic     rdy4, rdy5, rdy6;

  // halve, then add half the volume for the odd sublattice
  function automatic logic [IDX_W-1:0] eo_idx(input logic [LEX_W-1:0] lex,
                                              input logic [LEX_W-2:0] hv,
                                              input logic             odd);
    logic [LEX_W-1:0] sum;
    sum = (lex >> 1) + (odd ? LEX_W'(hv) : '0);
    return IDX_W'(sum);
  endfunction

  assign rdy6       = !v6_r || out_ready;
  assign rdy5       = !v5_r || rdy6;
  assign rdy4       = !v4_r || rdy5;
  assign base_ready = rdy4;

  // stage 4: (L-1)*stride per direction, from the strides already at hand
  always_comb begin
    st4_nxt.flags    = base.flags;
    st4_nxt.ls       = base.ls;
    st4_nxt.ls2      = base.ls2;
    st4_nxt.ls3      = base.ls3;
    st4_nxt.lex      = base.lex;
    st4_nxt.half_vol = base.vol[LEX_W-1:1];
    st4_nxt.dz       = base.ls - EXT_W'(1);
    st4_nxt.dy       = base.ls2 - S2_W'(base.ls);
    st4_nxt.dx       = base.ls3 - S3_W'(base.ls2);
    st4_nxt.dt       = base.vol - LEX_W'(base.ls3);
  end

  // stage 5: one step or a wrap across the lattice
  always_comb begin
    st5_nxt.flags    = st4_r.flags;
    st5_nxt.lex      = st4_r.lex;
    st5_nxt.half_vol = st4_r.half_vol;
    st5_nxt.up_t = st4_r.flags.top[DIR_T] ? st4_r.lex - st4_r.dt
                                          : st4_r.lex + LEX_W'(st4_r.ls3);
    st5_nxt.dn_t = st4_r.flags.zero[DIR_T] ? st4_r.lex + st4_r.dt
                                           : st4_r.lex - LEX_W'(st4_r.ls3);
    st5_nxt.up_x = st4_r.flags.top[DIR_X] ? st4_r.lex - LEX_W'(st4_r.dx)
                                          : st4_r.lex + LEX_W'(st4_r.ls2);
    st5_nxt.dn_x = st4_r.flags.zero[DIR_X] ? st4_r.lex + LEX_W'(st4_r.dx)
                                           : st4_r.lex - LEX_W'(st4_r.ls2);
    st5_nxt.up_y = st4_r.flags.top[DIR_Y] ? st4_r.lex - LEX_W'(st4_r.dy)
                                          : st4_r.lex + LEX_W'(st4_r.ls);
    st5_nxt.dn_y = st4_r.flags.zero[DIR_Y] ? st4_r.lex + LEX_W'(st4_r.dy)
                                           : st4_r.lex - LEX_W'(st4_r.ls);
    st5_nxt.up_z = st4_r.flags.top[DIR_Z] ? st4_r.lex - LEX_W'(st4_r.dz)
                                          : st4_r.lex + LEX_W'(1);
    st5_nxt.dn_z = st4_r.flags.zero[DIR_Z] ? st4_r.lex + LEX_W'(st4_r.dz)
                                           : st4_r.lex - LEX_W'(1);
  end

  // stage 6: neighbors always sit on the other sublattice
  always_comb begin
    st6_nxt = '0;
    st6_nxt.bad_coordinate = st5_r.flags.bad;
    if (!st5_r.flags.bad) begin
      st6_nxt.site_index = eo_idx(st5_r.lex,  st5_r.half_vol,  st5_r.flags.odd);
      st6_nxt.up_t       = eo_idx(st5_r.up_t, st5_r.half_vol, !st5_r.flags.odd);
      st6_nxt.down_t     = eo_idx(st5_r.dn_t, st5_r.half_vol, !st5_r.flags.odd);
      st6_nxt.up_x       = eo_idx(st5_r.up_x, st5_r.half_vol, !st5_r.flags.odd);
      st6_nxt.down_x     = eo_idx(st5_r.dn_x, st5_r.half_vol, !st5_r.flags.odd);
      st6_nxt.up_y       = eo_idx(st5_r.up_y, st5_r.half_vol, !st5_r.flags.odd);
      st6_nxt.down_y     = eo_idx(st5_r.dn_y, st5_r.half_vol, !st5_r.flags.odd);
      st6_nxt.up_z       = eo_idx(st5_r.up_z, st5_r.half_vol, !st5_r.flags.odd);
      st6_nxt.down_z     = eo_idx(st5_r.dn_z, st5_r.half_vol, !st5_r.flags.odd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= base_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && base_valid) st4_r <= st4_nxt;
    if (rdy5 && v4_r)       st5_r <= st5_nxt;
    if (rdy6 && v5_r)       st6_r <= st6_nxt;
  end

  assign out_rsp   = st6_r;
  assign out_valid = v6_r;

endmodule

@@ rtl/eolsi_checker.sv @@
// ----------------------------------------------------------------------------
// eolsi_checker
// Port-level checks on the indexer, bound to the top level.
// ----------------------------------------------------------------------------
module eolsi_checker (
  input logic                clk,
  input logic                rst_n,
  input eolsi_pkg::out_rsp_t out_rsp,
  input logic                out_valid,
  input logic                out_ready
);
  import eolsi_pkg::*;

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // bad site gives all-zero indices
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.bad_coordinate |->
      out_rsp.site_index == '0 && out_rsp.up_t == '0 && out_rsp.down_t == '0 &&
      out_rsp.up_x == '0 && out_rsp.down_x == '0 && out_rsp.up_y == '0 &&
      out_rsp.down_y == '0 && out_rsp.up_z == '0 && out_rsp.down_z == '0)
    else $error("nonzero index on bad site");

  // neighbors lie on the other sublattice, so never match the site
  a_nbr_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.bad_coordinate |->
      out_rsp.up_t != out_rsp.site_index && out_rsp.down_t != out_rsp.site_index &&
      out_rsp.up_x != out_rsp.site_index && out_rsp.down_x != out_rsp.site_index &&
      out_rsp.up_y != out_rsp.site_index && out_rsp.down_y != out_rsp.site_index &&
      out_rsp.up_z != out_rsp.site_index && out_rsp.down_z != out_rsp.site_index)
    else $error("neighbor index equals site index");

endmodule

bind even_odd_lattice_site_indexer eolsi_checker u_eolsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_rsp   (out_rsp),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
